// ===== design/wgh_pkg.sv =====
`default_nettype none
package wgh_pkg;

	// grid storage, cell (r,c) lives at r*MAX_COLS+c
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(CELLS);

	// field widths
	localparam int MODE_W  = 2;
	localparam int TIME_W  = 16;
	localparam int IDX_W   = 6;
	localparam int H_W     = 16;
	localparam int COEF_W  = 16;
	localparam int SIZE_W  = 7;
	localparam int ACCUM_W = 17;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// request modes
	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DISTURB = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NEIGHBOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd5;

endpackage
`default_nettype wire

// ===== design/wgh_if.sv =====
`default_nettype none
interface wgh_req_if;
	logic                              valid;
	logic                              ready;
	logic [wgh_pkg::MODE_W-1:0]        mode;
	logic [wgh_pkg::TIME_W-1:0]        elapsed;
	logic [wgh_pkg::IDX_W-1:0]         row;
	logic [wgh_pkg::IDX_W-1:0]         col;
	logic signed [wgh_pkg::H_W-1:0]    magnitude;

	modport source (output valid, mode, elapsed, row, col, magnitude, input ready);
	modport sink (input valid, mode, elapsed, row, col, magnitude, output ready);
endinterface

interface wgh_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [wgh_pkg::H_W-1:0]    height;
	logic                              stepped;
	logic                              out_of_range;

	modport source (output valid, height, stepped, out_of_range, input ready);
	modport sink (input valid, height, stepped, out_of_range, output ready);
endinterface
`default_nettype wire

// ===== design/wgh_ram.sv =====
`default_nettype none
module wgh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/wave_grid_height_solver_top.sv =====
`default_nettype none
// channel | dir | payload                                 | accepted when
// req     | in  | mode, elapsed, row, col, magnitude      | req.valid && req.ready
// rsp     | out | height, stepped, out_of_range           | rsp.valid && rsp.ready
// cfg     | in  | cfg_index, cfg_data                     | cfg_we
//
// after reset a clearing pass zeroes both planes, no request taken
// a step updates each interior cell with five reads of one plane port and
// three passes through the shared multiplier
// a disturb reads and writes the cell and its four neighbours in turn, a read
// passes ST_READ and ST_READ_WAIT, a tick without a step goes straight to ST_DONE
// one request is worked on at a time; a finished result waits in the output
// register while the next request is taken, from the cycle after the result loads
module wave_grid_height_solver_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	wgh_req_if.sink                                req,
	wgh_rsp_if.source                              rsp,
	input  wire logic                              cfg_we,
	input  wire logic [wgh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wgh_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wgh_pkg::*;

	localparam int NSUM_W = H_W + 2;
	localparam int PROD_W = COEF_W + NSUM_W;
	localparam int MAC_W  = PROD_W + 2;
	localparam logic signed [MAC_W-1:0] MAC_HI = MAC_W'(32767);
	localparam logic signed [MAC_W-1:0] MAC_LO = -MAC_W'(32768);
	localparam logic [ACCUM_W-1:0] ACCUM_MAX = {ACCUM_W{1'b1}};

	// phases of one cell update
	localparam logic [3:0] PH_ISSUE  = 4'd0;
	localparam logic [3:0] PH_CENTER = 4'd1;
	localparam logic [3:0] PH_UP     = 4'd2;
	localparam logic [3:0] PH_DOWN   = 4'd3;
	localparam logic [3:0] PH_LEFT   = 4'd4;
	localparam logic [3:0] PH_MUL0   = 4'd5;
	localparam logic [3:0] PH_MUL1   = 4'd6;
	localparam logic [3:0] PH_MUL2   = 4'd7;
	localparam logic [3:0] PH_ACC    = 4'd8;
	localparam logic [3:0] PH_WRITE  = 4'd9;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_CELL, ST_DIST_RD, ST_DIST_WR, ST_READ, ST_READ_WAIT, ST_DONE
	} state_t;

	state_t state_q;

	logic signed [COEF_W-1:0] coef_prev_q, coef_center_q, coef_neighbor_q;
	logic [TIME_W-1:0]        tstep_q;
	logic [SIZE_W-1:0]        rows_q, cols_q;

	logic [ACCUM_W-1:0]       accum_q;
	logic                     sel_q;
	logic [ADDR_W-1:0]        clr_q;
	logic [3:0]               ph_q;
	logic [IDX_W-1:0]         r_q, c_q;
	logic signed [H_W-1:0]    ctr_q, prv_q, mag_q;
	logic signed [NSUM_W-1:0] nsum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MAC_W-1:0]  mac_q;
	logic [2:0]               di_q;
	logic [ADDR_W-1:0]        k_q;
	logic signed [H_W-1:0]    res_height_q;
	logic                     res_stepped_q, res_oor_q;
	logic                     ov_q;
	logic signed [H_W-1:0]    height_q;
	logic                     stepped_q, oor_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_prev_q     <= '0;
			coef_center_q   <= '0;
			coef_neighbor_q <= '0;
			tstep_q         <= TIME_W'(1);
			rows_q          <= SIZE_W'(64);
			cols_q          <= SIZE_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_PREV:     coef_prev_q     <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_CENTER:   coef_center_q   <= $signed(cfg_data[COEF_W-1:0]);
				REG_COEF_NEIGHBOR: coef_neighbor_q <= $signed(cfg_data[COEF_W-1:0]);
				REG_TIME_STEP:     tstep_q         <= cfg_data[TIME_W-1:0];
				REG_GRID_ROWS:     rows_q          <= cfg_data[SIZE_W-1:0];
				REG_GRID_COLS:     cols_q          <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// grid size in use
	logic [SIZE_W-1:0] nr, nc;
	assign nr = (rows_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_q;
	assign nc = (cols_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_q;

	// request decode
	logic [SIZE_W-1:0]  rq_row, rq_col;
	logic               dist_bad, read_bad;
	logic [ACCUM_W:0]   accum_sum;
	logic [ACCUM_W-1:0] accum_sat;
	logic [ADDR_W-1:0]  rq_k;
	assign rq_row    = {1'b0, req.row};
	assign rq_col    = {1'b0, req.col};
	assign dist_bad  = (rq_row < SIZE_W'(2)) || (rq_row + SIZE_W'(3) > nr) ||
	                   (rq_col < SIZE_W'(2)) || (rq_col + SIZE_W'(3) > nc);
	assign read_bad  = (rq_row >= nr) || (rq_col >= nc);
	assign accum_sum = {1'b0, accum_q} + (ACCUM_W+1)'(req.elapsed);
	assign accum_sat = accum_sum[ACCUM_W] ? ACCUM_MAX : accum_sum[ACCUM_W-1:0];
	assign rq_k      = ADDR_W'(req.row * MAX_COLS) + ADDR_W'(req.col);

	// cell addresses
	logic [ADDR_W-1:0] cell_k, dist_addr;
	assign cell_k = ADDR_W'(r_q * MAX_COLS) + ADDR_W'(c_q);
	always_comb begin
		case (di_q)
			3'd0:    dist_addr = k_q;
			3'd1:    dist_addr = k_q + ADDR_W'(1);
			3'd2:    dist_addr = k_q - ADDR_W'(1);
			3'd3:    dist_addr = k_q + ADDR_W'(MAX_COLS);
			default: dist_addr = k_q - ADDR_W'(MAX_COLS);
		endcase
	end

	// plane ports seen as current and previous
	logic [ADDR_W-1:0] cur_raddr, prev_raddr, cur_waddr;
	logic [H_W-1:0]    cur_wdata, prev_wdata;
	logic              cur_we, prev_we, clearing;
	logic [H_W-1:0]    a_rdata, b_rdata;
	logic signed [H_W-1:0] cur_s, prev_s;
	assign cur_s  = $signed(sel_q ? b_rdata : a_rdata);
	assign prev_s = $signed(sel_q ? a_rdata : b_rdata);
	assign clearing = (state_q == ST_CLEAR);

	// shared multiplier operand select
	logic signed [COEF_W-1:0] mul_a;
	logic signed [NSUM_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_d;
	always_comb begin
		case (ph_q)
			PH_MUL0: begin mul_a = coef_prev_q;     mul_b = NSUM_W'(prv_q); end
			PH_MUL1: begin mul_a = coef_center_q;   mul_b = NSUM_W'(ctr_q); end
			default: begin mul_a = coef_neighbor_q; mul_b = nsum_q;         end
		endcase
		prod_d = mul_a * mul_b;
	end

	// round half up to q8.8 and saturate
	logic signed [MAC_W-1:0] rnd;
	always_comb begin
		rnd = (mac_q + MAC_W'(8192)) >>> 14;
		if (rnd > MAC_HI) begin
			prev_wdata = 16'h7fff;
		end else if (rnd < MAC_LO) begin
			prev_wdata = 16'h8000;
		end else begin
			prev_wdata = rnd[H_W-1:0];
		end
	end

	// disturb add with saturation
	logic signed [H_W-1:0] dist_add;
	logic signed [H_W:0]   dist_sum;
	assign dist_add = (di_q == 3'd0) ? mag_q : (mag_q >>> 1);
	assign dist_sum = {cur_s[H_W-1], cur_s} + {dist_add[H_W-1], dist_add};
	always_comb begin
		if (dist_sum[H_W] != dist_sum[H_W-1]) begin
			cur_wdata = dist_sum[H_W] ? 16'h8000 : 16'h7fff;
		end else begin
			cur_wdata = dist_sum[H_W-1:0];
		end
	end

	// read address and write strobe per state
	always_comb begin
		cur_raddr  = k_q;
		prev_raddr = cell_k;
		cur_waddr  = dist_addr;
		cur_we     = 1'b0;
		prev_we    = 1'b0;
		case (state_q)
			ST_CELL: begin
				case (ph_q)
					PH_ISSUE:  cur_raddr = cell_k;
					PH_CENTER: cur_raddr = cell_k - ADDR_W'(MAX_COLS);
					PH_UP:     cur_raddr = cell_k + ADDR_W'(MAX_COLS);
					PH_DOWN:   cur_raddr = cell_k - ADDR_W'(1);
					PH_LEFT:   cur_raddr = cell_k + ADDR_W'(1);
					default:   cur_raddr = cell_k;
				endcase
				prev_we = (ph_q == PH_WRITE);
			end
			ST_DIST_RD: cur_raddr = dist_addr;
			ST_DIST_WR: cur_we = 1'b1;
			default: ;
		endcase
	end

	// two planes, mapped by plane select
	logic              a_we, b_we;
	logic [ADDR_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
	logic [H_W-1:0]    a_wdata, b_wdata;
	always_comb begin
		a_raddr = sel_q ? prev_raddr : cur_raddr;
		b_raddr = sel_q ? cur_raddr : prev_raddr;
		if (clearing) begin
			a_we = 1'b1; a_waddr = clr_q; a_wdata = '0;
			b_we = 1'b1; b_waddr = clr_q; b_wdata = '0;
		end else if (sel_q) begin
			a_we = prev_we; a_waddr = cell_k;    a_wdata = prev_wdata;
			b_we = cur_we;  b_waddr = cur_waddr; b_wdata = cur_wdata;
		end else begin
			a_we = cur_we;  a_waddr = cur_waddr; a_wdata = cur_wdata;
			b_we = prev_we; b_waddr = cell_k;    b_wdata = prev_wdata;
		end
	end

	wgh_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_plane_a (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	wgh_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_plane_b (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	logic last_col, last_row;
	assign last_col = ({1'b0, c_q} == nc - SIZE_W'(2));
	assign last_row = ({1'b0, r_q} == nr - SIZE_W'(2));

	// outcome of the offered request
	logic   tick_fire, grid_big, req_oor;
	state_t idle_next;
	assign tick_fire = (req.mode == MODE_TICK) && ({1'b0, tstep_q} <= accum_sat);
	assign grid_big  = (nr >= SIZE_W'(3)) && (nc >= SIZE_W'(3));
	assign req_oor   = ((req.mode == MODE_DISTURB) && dist_bad) ||
	                   ((req.mode == MODE_READ) && read_bad);
	always_comb begin
		case (req.mode)
			MODE_TICK:    idle_next = (tick_fire && grid_big) ? ST_CELL : ST_DONE;
			MODE_DISTURB: idle_next = dist_bad ? ST_DONE : ST_DIST_RD;
			MODE_READ:    idle_next = read_bad ? ST_DONE : ST_READ;
			default:      idle_next = ST_DONE;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			accum_q       <= '0;
			sel_q         <= 1'b0;
			ph_q          <= PH_ISSUE;
			ov_q          <= 1'b0;
			r_q           <= '0;
			c_q           <= '0;
			ctr_q         <= '0;
			prv_q         <= '0;
			mag_q         <= '0;
			nsum_q        <= '0;
			prod_q        <= '0;
			mac_q         <= '0;
			di_q          <= '0;
			k_q           <= '0;
			res_height_q  <= '0;
			res_stepped_q <= 1'b0;
			res_oor_q     <= 1'b0;
			height_q      <= '0;
			stepped_q     <= 1'b0;
			oor_q         <= 1'b0;
		end else begin
			// output valid: set on load, cleared when taken
			if (state_q == ST_DONE && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						res_height_q  <= '0;
						res_stepped_q <= tick_fire;
						res_oor_q     <= req_oor;
						k_q           <= rq_k;
						mag_q         <= req.magnitude;
						di_q          <= '0;
						state_q       <= idle_next;
						if (req.mode == MODE_TICK) begin
							accum_q <= tick_fire ? '0 : accum_sat;
						end
						if (tick_fire) begin
							if (grid_big) begin
								r_q  <= IDX_W'(1);
								c_q  <= IDX_W'(1);
								ph_q <= PH_ISSUE;
							end else begin
								sel_q <= ~sel_q;
							end
						end
					end
				end
				ST_CELL: begin
					ph_q <= (ph_q == PH_WRITE) ? PH_ISSUE : ph_q + 4'd1;
					case (ph_q)
						PH_CENTER: begin
							ctr_q <= cur_s;
							prv_q <= prev_s;
						end
						PH_UP:   nsum_q <= NSUM_W'(cur_s);
						PH_DOWN: nsum_q <= nsum_q + NSUM_W'(cur_s);
						PH_LEFT: nsum_q <= nsum_q + NSUM_W'(cur_s);
						PH_MUL0: begin
							nsum_q <= nsum_q + NSUM_W'(cur_s);
							prod_q <= prod_d;
						end
						PH_MUL1: begin
							mac_q  <= MAC_W'(prod_q);
							prod_q <= prod_d;
						end
						PH_MUL2: begin
							mac_q  <= mac_q + MAC_W'(prod_q);
							prod_q <= prod_d;
						end
						PH_ACC: mac_q <= mac_q + MAC_W'(prod_q);
						PH_WRITE: begin
							if (last_col) begin
								c_q <= IDX_W'(1);
								r_q <= r_q + IDX_W'(1);
								if (last_row) begin
									sel_q   <= ~sel_q;
									state_q <= ST_DONE;
								end
							end else begin
								c_q <= c_q + IDX_W'(1);
							end
						end
						default: ;
					endcase
				end
				ST_DIST_RD: state_q <= ST_DIST_WR;
				ST_DIST_WR: begin
					di_q <= di_q + 3'd1;
					state_q <= (di_q == 3'd4) ? ST_DONE : ST_DIST_RD;
				end
				ST_READ: state_q <= ST_READ_WAIT;
				ST_READ_WAIT: begin
					res_height_q <= cur_s;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (!ov_q || rsp.ready) begin
						height_q  <= res_height_q;
						stepped_q <= res_stepped_q;
						oor_q     <= res_oor_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = ov_q;
	assign rsp.height       = height_q;
	assign rsp.stepped      = stepped_q;
	assign rsp.out_of_range = oor_q;

endmodule
`default_nettype wire

// ===== design/wgh_checker.sv =====
`default_nettype none
module wgh_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic signed [wgh_pkg::H_W-1:0] height,
	input wire logic                        stepped,
	input wire logic                        out_of_range
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(height) && $stable(stepped) && $stable(out_of_range))
		else $error("result changed while stalled");

	// the block is busy in the cycle after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a step and a range flag never come together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stepped && out_of_range))
		else $error("stepped and out_of_range both set");

	// only a good read carries a height
	a_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && height != 0 |-> !stepped && !out_of_range)
		else $error("height on a non-read result");

endmodule

bind wave_grid_height_solver_top wgh_checker u_wgh_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.height(rsp.height),
	.stepped(rsp.stepped),
	.out_of_range(rsp.out_of_range)
);
`default_nettype wire
